// ===== rtl/core/gidr_pkg.sv =====
// ----------------------------------------------------------------------------
// gidr_pkg
// Shared types, constants and CORDIC arctangent table for the dead-reckoning block.
// ----------------------------------------------------------------------------
package gidr_pkg;

    localparam logic [1:0] OP_IMU   = 2'd0;
    localparam logic [1:0] OP_POSE  = 2'd1;
    localparam logic [1:0] OP_FIX   = 2'd2;
    localparam logic [1:0] OP_SPEED = 2'd3;

    localparam logic [1:0] FIX_SINGLE     = 2'd0;
    localparam logic [1:0] FIX_PSRDIFF    = 2'd1;
    localparam logic [1:0] FIX_NARROW_INT = 2'd2;
    localparam logic [1:0] FIX_OTHER      = 2'd3;

    localparam int CORDIC_ITERS = 16;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [33:0] QTURN    = 34'sd268435456;

    // CORDIC rotator start request
    typedef struct packed {
        logic        start;
        logic [29:0] angle;   // 2^30 per turn
    } cordic_req_t;

    // CORDIC rotator status and results
    typedef struct packed {
        logic               done;
        logic signed [33:0] co;
        logic signed [33:0] si;
    } cordic_rsp_t;

    function automatic logic signed [33:0] atan_val(input logic [3:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                4'd0:  r = 34'sd134217728;
                4'd1:  r = 34'sd79233351;
                4'd2:  r = 34'sd41864727;
                4'd3:  r = 34'sd21251189;
                4'd4:  r = 34'sd10666833;
                4'd5:  r = 34'sd5338616;
                4'd6:  r = 34'sd2669960;
                4'd7:  r = 34'sd1335061;
                4'd8:  r = 34'sd667541;
                4'd9:  r = 34'sd333772;
                4'd10: r = 34'sd166886;
                4'd11: r = 34'sd83443;
                4'd12: r = 34'sd41722;
                4'd13: r = 34'sd20861;
                4'd14: r = 34'sd10430;
                default: r = 34'sd5215;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > 34'sd2147483647)
                return 32'sh7FFFFFFF;
            else if (v < -34'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

endpackage

// ===== rtl/core/gnss_imu_dead_reckoning_top.sv =====
// ----------------------------------------------------------------------------
// gnss_imu_dead_reckoning_top
// Fuses GNSS poses, fix type, speed and IMU yaw rate into an output pose.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | in_valid/in_stall    | opcode .. speed_raw
//  output  | res_valid/res_stall  | out_x .. out_valid
//
//  A transaction is accepted in IDLE. Every result runs the 16-step CORDIC on
//  one shared rotator for the orientation; an IMU step in differential fix,
//  once a pose has been seen, runs it twice (step direction, then orientation).
//  The result sits in an output register; the next input is taken once the
//  result is handed off. Reset is asynchronous and needs no clearing pass.
//  in_stall is high whenever the block is busy or a result is still pending.
module gnss_imu_dead_reckoning_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic               level_identity,
    input  logic signed [15:0] yaw_rate,
    input  logic signed [31:0] gnss_x,
    input  logic signed [31:0] gnss_y,
    input  logic [15:0]        gnss_heading,
    input  logic [1:0]         fix_kind,
    input  logic signed [15:0] speed_raw,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic [15:0]        out_heading,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic               out_valid
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DR    = 4'd1;
    localparam logic [3:0] S_DRW   = 4'd2;
    localparam logic [3:0] S_MX    = 4'd3;
    localparam logic [3:0] S_MY    = 4'd4;
    localparam logic [3:0] S_AY    = 4'd5;
    localparam logic [3:0] S_OR    = 4'd6;
    localparam logic [3:0] S_ORW   = 4'd7;
    localparam logic [3:0] S_OUTX  = 4'd8;
    localparam logic [3:0] S_OUTY  = 4'd9;
    localparam logic [3:0] S_HOLD  = 4'd10;

    logic [3:0] state_reg, state_next;

    logic [15:0]        gyaw_reg, gyaw_next;
    logic [15:0]        yest_reg, yest_next;
    logic [15:0]        yfault_reg, yfault_next;
    logic [15:0]        head_reg, head_next;
    logic signed [31:0] px_reg, px_next;
    logic signed [31:0] py_reg, py_next;
    logic signed [31:0] ox_reg, ox_next;
    logic signed [31:0] oy_reg, oy_next;
    logic [1:0]         fnow_reg, fnow_next;
    logic [1:0]         fbef_reg, fbef_next;
    logic signed [15:0] spd_reg, spd_next;
    logic               seen_reg, seen_next;
    logic               live_reg, live_next;
    logic               rv_reg, rv_next;

    logic signed [15:0] dist_reg, dist_next;
    logic signed [33:0] cs_reg, cs_next;
    logic signed [33:0] sn_reg, sn_next;
    logic signed [49:0] prod_reg, prod_next;

    logic signed [31:0] ox_o_reg, ox_o_next;
    logic signed [31:0] oy_o_reg, oy_o_next;
    logic signed [15:0] qz_reg, qz_next;
    logic signed [15:0] qw_reg, qw_next;

    gidr_pkg::cordic_req_t creq;
    gidr_pkg::cordic_rsp_t crsp;

    gidr_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            gyaw_reg   <= '0;
            yest_reg   <= '0;
            yfault_reg <= '0;
            head_reg   <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            ox_reg     <= -32'sd1024;
            oy_reg     <= 32'sd1024;
            fnow_reg   <= gidr_pkg::FIX_OTHER;
            fbef_reg   <= gidr_pkg::FIX_OTHER;
            spd_reg    <= '0;
            seen_reg   <= 1'b0;
            live_reg   <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            gyaw_reg   <= gyaw_next;
            yest_reg   <= yest_next;
            yfault_reg <= yfault_next;
            head_reg   <= head_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            fnow_reg   <= fnow_next;
            fbef_reg   <= fbef_next;
            spd_reg    <= spd_next;
            seen_reg   <= seen_next;
            live_reg   <= live_next;
            rv_reg     <= rv_next;
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        cs_reg   <= cs_next;
        sn_reg   <= sn_next;
        prod_reg <= prod_next;
        ox_o_reg <= ox_o_next;
        oy_o_reg <= oy_o_next;
        qz_reg   <= qz_next;
        qw_reg   <= qw_next;
    end

    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic signed [33:0] r;
        begin
            r = (v + 34'sd16384) >>> 15;
            if (r > 34'sd32767)
                return 16'sh7FFF;
            else if (r < -34'sd32768)
                return 16'sh8000;
            else
                return r[15:0];
        end
    endfunction

    always_comb
    begin
        logic        accept;
        logic [15:0] est;
        logic signed [15:0] inc;
        logic [15:0] rmag;
        logic [15:0] rq;
        logic [15:0] mag;
        logic [25:0] dq;
        logic [15:0] dmag;
        logic signed [33:0] step;
        state_next  = state_reg;
        gyaw_next   = gyaw_reg;
        yest_next   = yest_reg;
        yfault_next = yfault_reg;
        head_next   = head_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        fnow_next   = fnow_reg;
        fbef_next   = fbef_reg;
        spd_next    = spd_reg;
        seen_next   = seen_reg;
        live_next   = live_reg;
        rv_next     = rv_reg;
        dist_next   = dist_reg;
        cs_next     = cs_reg;
        sn_next     = sn_reg;
        prod_next   = prod_reg;
        ox_o_next   = ox_o_reg;
        oy_o_next   = oy_o_reg;
        qz_next     = qz_reg;
        qw_next     = qw_reg;
        creq.start  = 1'b0;
        creq.angle  = {head_reg, 14'b0} >> 1;
        accept = in_valid && !in_stall;
        // rate/20 truncated toward zero: |rate| * ceil(2^20/20) >> 20
        rmag = yaw_rate[15] ? 16'(-yaw_rate) : yaw_rate;
        rq   = 16'((33'(rmag) * 33'd52429) >> 20);
        inc  = yaw_rate[15] ? (16'sd0 - $signed(rq)) : $signed(rq);
        est  = yest_reg;
        mag  = spd_reg[15] ? 16'(-spd_reg) : spd_reg;
        // round(mag*1024/3600) = (mag*256 + 450) / 900 via reciprocal
        dq   = 26'({mag, 8'b0} + 24'd450);
        dmag = 16'((64'(dq) * 64'd19088744) >> 34);
        step = prod_reg[49] ? -34'sd1 : 34'sd0;

        if (rv_reg && !res_stall)
            rv_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_OR;
                    unique case (opcode)
                        gidr_pkg::OP_IMU:
                        begin
                            if (level_identity)
                                yfault_next = gyaw_reg;
                            else if (yfault_reg != gyaw_reg)
                                yest_next = gyaw_reg;
                            if (seen_reg)
                            begin
                                est = yest_next + 16'(inc);
                                live_next = 1'b1;
                                dist_next = spd_reg[15] ? 16'(-dmag) : dmag;
                                unique case (fnow_reg)
                                    gidr_pkg::FIX_SINGLE:
                                    begin
                                        head_next = est;
                                        yest_next = est;
                                    end
                                    gidr_pkg::FIX_PSRDIFF:
                                    begin
                                        head_next = est;
                                        yest_next = est;
                                        state_next = S_DR;
                                    end
                                    gidr_pkg::FIX_NARROW_INT:
                                    begin
                                        head_next = yest_next;
                                        ox_next = '0;
                                        oy_next = '0;
                                    end
                                    default:
                                        head_next = yest_next;
                                endcase
                            end
                        end
                        gidr_pkg::OP_POSE:
                        begin
                            gyaw_next = gnss_heading;
                            if (fnow_reg == gidr_pkg::FIX_SINGLE)
                            begin
                                if (fbef_reg == gidr_pkg::FIX_NARROW_INT)
                                begin
                                    ox_next = gidr_pkg::sat32(34'(px_reg) - 34'(gnss_x));
                                    oy_next = gidr_pkg::sat32(34'(py_reg) - 34'(gnss_y));
                                end
                                px_next = gnss_x;
                                py_next = gnss_y;
                            end
                            else if (fnow_reg == gidr_pkg::FIX_PSRDIFF)
                            begin
                                if (!seen_reg)
                                begin
                                    px_next = gnss_x;
                                    py_next = gnss_y;
                                end
                            end
                            else
                            begin
                                px_next = gnss_x;
                                py_next = gnss_y;
                            end
                            seen_next = 1'b1;
                            fbef_next = fnow_reg;
                        end
                        gidr_pkg::OP_FIX:
                            fnow_next = fix_kind;
                        default:
                            spd_next = speed_raw;
                    endcase
                end
            end
            S_DR:
            begin
                creq.start = 1'b1;
                creq.angle = {head_reg, 14'b0};
                state_next = S_DRW;
            end
            S_DRW:
            begin
                if (crsp.done)
                begin
                    cs_next = crsp.co;
                    sn_next = crsp.si;
                    state_next = S_MX;
                end
            end
            S_MX:
            begin
                prod_next = 50'(dist_reg) * 50'(cs_reg);
                state_next = S_MY;
            end
            S_MY:
            begin
                step = 34'((prod_reg + 50'sd536870912) >>> 30);
                px_next = gidr_pkg::sat32(34'(px_reg) + step);
                prod_next = 50'(dist_reg) * 50'(sn_reg);
                state_next = S_AY;
            end
            S_AY:
            begin
                step = 34'((prod_reg + 50'sd536870912) >>> 30);
                py_next = gidr_pkg::sat32(34'(py_reg) + step);
                state_next = S_OR;
            end
            S_OR:
            begin
                creq.start = 1'b1;
                creq.angle = 30'({head_reg, 13'b0});
                state_next = S_ORW;
            end
            S_ORW:
            begin
                if (crsp.done)
                begin
                    qz_next = to_q15(crsp.si);
                    qw_next = to_q15(crsp.co);
                    state_next = S_OUTX;
                end
            end
            S_OUTX:
            begin
                ox_o_next = gidr_pkg::sat32(34'(px_reg) + 34'(ox_reg));
                state_next = S_OUTY;
            end
            S_OUTY:
            begin
                oy_o_next = gidr_pkg::sat32(34'(py_reg) + 34'(oy_reg));
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!rv_reg || !res_stall)
                begin
                    rv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_stall    = (state_reg != S_IDLE) || rv_reg;
    assign res_valid   = rv_reg;
    assign out_x       = ox_o_reg;
    assign out_y       = oy_o_reg;
    assign out_heading = head_reg;
    assign quat_z      = qz_reg;
    assign quat_w      = qw_reg;
    assign out_valid   = live_reg;

endmodule

// ===== rtl/core/gidr_cordic.sv =====
// ----------------------------------------------------------------------------
// gidr_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module gidr_cordic
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gidr_pkg::cordic_req_t req,
    output gidr_pkg::cordic_rsp_t rsp
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               neg_reg, neg_next;
    logic [3:0]         iter_reg, iter_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        iter_reg <= iter_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    always_comb
    begin
        logic signed [33:0] z0;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        z0 = '0;
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        if (req.start)
        begin
            // fold angle into [-quarter, quarter] turn
            z0 = req.angle[29] ? ($signed({4'b0, req.angle}) - 34'sd1073741824)
                               : $signed({4'b0, req.angle});
            neg_next = 1'b0;
            if (z0 > gidr_pkg::QTURN)
            begin
                z0 = z0 - (gidr_pkg::QTURN <<< 1);
                neg_next = 1'b1;
            end
            else if (z0 < -gidr_pkg::QTURN)
            begin
                z0 = z0 + (gidr_pkg::QTURN <<< 1);
                neg_next = 1'b1;
            end
            z_next    = z0;
            x_next    = gidr_pkg::CORDIC_K;
            y_next    = '0;
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - gidr_pkg::atan_val(iter_reg);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + gidr_pkg::atan_val(iter_reg);
            end
            iter_next = iter_reg + 4'd1;
            if (iter_reg == 4'(gidr_pkg::CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                begin
                    x_next = -x_next;
                    y_next = -y_next;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.co   = x_reg;
    assign rsp.si   = y_reg;

endmodule
